// ===== hw/rtl/prq_pkg.sv =====
// Package with the constants, types and helpers of the packet ring queue.
`timescale 1ns / 1ps

package prq_pkg;

  localparam int QUEUE_SLOTS = 8;
  localparam int SLOT_BYTES  = 2048;
  localparam int LIMIT_MAX   = 2048;
  localparam int LIMIT_CAP   = (LIMIT_MAX < SLOT_BYTES) ? LIMIT_MAX : SLOT_BYTES;

  localparam int LEN_W  = 12;
  localparam int BYTE_W = 8;
  localparam int QS_W   = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int OFF_W  = $clog2(SLOT_BYTES);
  localparam int RAM_DEPTH = QUEUE_SLOTS * SLOT_BYTES;
  localparam int ADDR_W = $clog2(RAM_DEPTH);

  localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(1518);

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_DROPPED = 2'd1,
    ST_OVER    = 2'd2,
    ST_EMPTY   = 2'd3
  } prq_status_t;

  typedef logic [QS_W-1:0] slot_t;

  // Result fields known at acceptance; the byte itself follows from the RAM.
  typedef struct packed {
    logic              from_ram;
    logic              last;
    logic [LEN_W-1:0]  length;
    prq_status_t       status;
  } prq_meta_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [ADDR_W-1:0]  addr;
    logic [BYTE_W-1:0]  wdata;
  } prq_ram_req_t;

  function automatic slot_t next_slot(input slot_t s);
    return (s == QS_W'(QUEUE_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input slot_t s,
                                                  input logic [OFF_W-1:0] off);
    return ADDR_W'(s) * ADDR_W'(SLOT_BYTES) + ADDR_W'(off);
  endfunction

endpackage

// ===== hw/rtl/prq_in_if.sv =====
// Request channel interface carrying push and pop requests.
`timescale 1ns / 1ps

interface prq_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, cmd, data_byte, last_byte, input ready);
  modport sink   (input valid, cmd, data_byte, last_byte, output ready);
endinterface

// ===== hw/rtl/prq_out_if.sv =====
// Result channel interface carrying one result per request.
`timescale 1ns / 1ps

interface prq_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [11:0] out_length;
  logic [1:0]  status;

  modport source (output valid, out_byte, out_last, out_length, status, input ready);
  modport sink   (input valid, out_byte, out_last, out_length, status, output ready);
endinterface

// ===== hw/rtl/prq_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hw/rtl/prq_ctrl.sv =====
// Ring control: slot pointers, frame tracking, limit register and RAM requests.
`timescale 1ns / 1ps

module prq_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [prq_pkg::LEN_W-1:0]  cfg_data,
  input  logic                       accept,
  input  logic                       cmd,
  input  logic [prq_pkg::BYTE_W-1:0] data_byte,
  input  logic                       last_byte,
  output prq_pkg::prq_ram_req_t      ram_req,
  output prq_pkg::prq_meta_t         meta
);
  import prq_pkg::*;

  logic [LEN_W-1:0] frame_limit;
  slot_t            head_slot, head_slot_next;
  slot_t            tail_slot, tail_slot_next;
  logic [LEN_W-1:0] write_count, write_count_next;
  logic [OFF_W-1:0] read_offset, read_offset_next;
  logic             in_frame, in_frame_next;
  logic             dropping, dropping_next;
  logic [LEN_W-1:0] slot_lengths [QUEUE_SLOTS];

  logic [LEN_W-1:0] limit;
  logic [LEN_W-1:0] wc;
  logic [LEN_W-1:0] wc_inc;
  logic             drop_now;
  logic             len_we;
  logic [LEN_W-1:0] pop_len;
  logic [LEN_W:0]   off_plus;

  always_comb begin
    if (frame_limit == '0) begin
      limit = LEN_W'(1);
    end else if (frame_limit > LEN_W'(LIMIT_CAP)) begin
      limit = LEN_W'(LIMIT_CAP);
    end else begin
      limit = frame_limit;
    end
  end

  assign pop_len  = slot_lengths[tail_slot];
  assign off_plus = {1'b0, LEN_W'(read_offset)} + 1'b1;
  assign wc       = in_frame ? write_count : '0;
  assign drop_now = in_frame ? dropping : (next_slot(head_slot) == tail_slot);
  assign wc_inc   = wc + 1'b1;

  always_comb begin
    head_slot_next   = head_slot;
    tail_slot_next   = tail_slot;
    write_count_next = write_count;
    read_offset_next = read_offset;
    in_frame_next    = in_frame;
    dropping_next    = dropping;
    len_we           = 1'b0;
    ram_req          = '0;
    ram_req.wdata    = data_byte;
    meta             = '0;
    meta.status      = ST_DONE;

    if (cmd == CMD_PUSH) begin
      if (drop_now) begin
        meta.status   = ST_DROPPED;
        in_frame_next = !last_byte;
        dropping_next = !last_byte;
      end else begin
        write_count_next = wc;
        if (wc < limit) begin
          ram_req.we       = accept;
          ram_req.addr     = slot_addr(head_slot, wc[OFF_W-1:0]);
          write_count_next = wc_inc;
        end else begin
          meta.status = ST_OVER;
        end
        dropping_next = 1'b0;
        if (last_byte) begin
          len_we           = accept;
          head_slot_next   = next_slot(head_slot);
          in_frame_next    = 1'b0;
        end else begin
          in_frame_next    = 1'b1;
        end
      end
    end else begin
      if (tail_slot == head_slot) begin
        meta.status = ST_EMPTY;
      end else begin
        ram_req.re    = accept;
        ram_req.addr  = slot_addr(tail_slot, read_offset);
        meta.from_ram = 1'b1;
        meta.length   = pop_len;
        if (off_plus >= {1'b0, pop_len}) begin
          meta.last        = 1'b1;
          tail_slot_next   = next_slot(tail_slot);
          read_offset_next = '0;
        end else begin
          read_offset_next = OFF_W'(off_plus);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= LIMIT_RESET;
      head_slot   <= '0;
      tail_slot   <= '0;
      write_count <= '0;
      read_offset <= '0;
      in_frame    <= 1'b0;
      dropping    <= 1'b0;
    end else begin
      if (cfg_we) begin
        frame_limit <= cfg_data;
      end
      if (accept) begin
        head_slot   <= head_slot_next;
        tail_slot   <= tail_slot_next;
        write_count <= write_count_next;
        read_offset <= read_offset_next;
        in_frame    <= in_frame_next;
        dropping    <= dropping_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      slot_lengths[head_slot] <= write_count_next;
    end
  end

endmodule

// ===== hw/rtl/prq_pipe.sv =====
// Two-stage result pipeline: RAM read stage and output register.
`timescale 1ns / 1ps

module prq_pipe (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  prq_pkg::prq_meta_t         meta,
  input  logic [prq_pkg::BYTE_W-1:0] ram_q,
  prq_out_if.source                  rsp_ch
);
  import prq_pkg::*;

  logic      s1_valid;
  prq_meta_t s1_meta;
  logic      out_valid;
  logic      s2_load;

  // The RAM only reads on acceptance, so its data holds while stage one waits.
  assign s2_load  = s1_valid && (!out_valid || rsp_ch.ready);
  assign in_ready = !s1_valid || s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_load) begin
        out_valid <= 1'b1;
      end else if (rsp_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_meta <= meta;
    end
    if (s2_load) begin
      rsp_ch.out_byte   <= s1_meta.from_ram ? ram_q : '0;
      rsp_ch.out_last   <= s1_meta.last;
      rsp_ch.out_length <= s1_meta.length;
      rsp_ch.status     <= s1_meta.status;
    end
  end

  assign rsp_ch.valid = out_valid;

endmodule

// ===== hw/rtl/packet_ring_queue.sv =====
// Packet ring queue top level: a ring of frame slots with drop-on-full.
// Each request, push or pop, goes through the registered RAM read and the
// output register; with the result side ready, one request is taken every
// cycle. The rate is set by the single-port frame RAM, which serves either one
// byte write or one byte read per cycle, followed by its registered read and
// an output register. A frame is dropped whole when the ring is full at its
// first byte, bytes past the frame limit are discarded, and pops see only
// committed frames. The frame store needs no clearing after reset.
`timescale 1ns / 1ps

module packet_ring_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [prq_pkg::LEN_W-1:0] cfg_data,
  prq_in_if.sink                    cmd_ch,
  prq_out_if.source                 rsp_ch
);
  import prq_pkg::*;

  prq_ram_req_t      ram_req;
  prq_meta_t         meta;
  logic [BYTE_W-1:0] ram_q;
  logic              accept;

  assign accept = cmd_ch.valid && cmd_ch.ready;

  prq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .cmd       (cmd_ch.cmd),
    .data_byte (cmd_ch.data_byte),
    .last_byte (cmd_ch.last_byte),
    .ram_req   (ram_req),
    .meta      (meta)
  );

  prq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .re    (ram_req.re),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_q)
  );

  prq_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd_ch.valid),
    .in_ready (cmd_ch.ready),
    .meta     (meta),
    .ram_q    (ram_q),
    .rsp_ch   (rsp_ch)
  );

endmodule

// ===== hw/rtl/prq_checker.sv =====
// Port-level checker for the packet ring queue, bound to the top level.
`timescale 1ns / 1ps

module prq_prop_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_last,
  input logic [11:0] out_length,
  input logic [1:0]  status
);
  import prq_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_byte))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> out_byte == '0 && out_length == '0 && !out_last)
    else $error("empty pop carries data");

  a_push: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_DROPPED || status == ST_OVER)
      |-> out_byte == '0 && out_length == '0 && !out_last)
    else $error("push result carries pop data");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> status == ST_DONE && out_length != '0)
    else $error("last byte without a stored length");

endmodule

bind packet_ring_queue prq_prop_checker u_prq_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (rsp_ch.valid),
  .out_ready  (rsp_ch.ready),
  .out_byte   (rsp_ch.out_byte),
  .out_last   (rsp_ch.out_last),
  .out_length (rsp_ch.out_length),
  .status     (rsp_ch.status)
);
